// ===== sv/nal_exp_golomb_stream_decoder_macros.svh =====
// Assertion helpers used by the decoder back end (egsd_back).
`ifndef NAL_EXP_GOLOMB_STREAM_DECODER_MACROS_SVH
`define NAL_EXP_GOLOMB_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define EGSD_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("egsd assertion failed");

// Next-cycle implication, checked out of reset.
`define EGSD_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("egsd assertion failed");

`endif

// ===== sv/egsd_pkg.sv =====
package egsd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 33;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned CNT_W   = 6;

  localparam logic [BYTE_W-1:0] BYTE_ZERO   = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ESCAPE = 8'h03;

  // Entry handed from the front to the bit engine
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              clear;
  } egsd_qent_t;

  // Push/pop handshake between front, queue and back
  typedef struct packed {
    logic       valid;
    egsd_qent_t ent;
  } egsd_qpush_t;

endpackage

// ===== sv/egsd_if.sv =====
interface egsd_in_if;
  logic                         valid;
  logic                         ready;
  logic [egsd_pkg::BYTE_W-1:0]  data_byte;
  logic                         start_of_unit;

  modport source (output valid, output data_byte, output start_of_unit, input ready);
  modport sink   (input valid, input data_byte, input start_of_unit, output ready);
endinterface

interface egsd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [egsd_pkg::VALUE_W-1:0] code_value;
  logic                               code_error;
  logic                               last_of_byte;

  modport source (output valid, output code_value, output code_error,
                  output last_of_byte, input ready);
  modport sink   (input valid, input code_value, input code_error,
                  input last_of_byte, output ready);
endinterface

// ===== sv/egsd_front.sv =====
module egsd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  egsd_in_if.sink              in_bus,
  input  logic                 q_ready,
  output egsd_pkg::egsd_qpush_t q_push
);
  import egsd_pkg::*;

  logic [1:0] zero_run_r, zero_run_nxt;
  logic       accept;
  logic [1:0] run_eff;
  logic       escape;

  assign in_bus.ready = q_ready;
  assign accept       = in_bus.valid && in_bus.ready;

  // start of unit clears the zero count before this beat is looked at
  assign run_eff = in_bus.start_of_unit ? 2'd0 : zero_run_r;
  assign escape  = (run_eff == 2'd2) && (in_bus.data_byte == BYTE_ESCAPE);

  always_comb begin
    zero_run_nxt = zero_run_r;
    if (accept) begin
      if (escape) begin
        zero_run_nxt = 2'd0;
      end else if (in_bus.data_byte == BYTE_ZERO) begin
        zero_run_nxt = (run_eff == 2'd2) ? 2'd2 : run_eff + 2'd1;
      end else begin
        zero_run_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= 2'd0;
    end else begin
      zero_run_r <= zero_run_nxt;
    end
  end

  // escape bytes never reach the queue
  assign q_push.valid         = accept && !escape;
  assign q_push.ent.data_byte = in_bus.data_byte;
  assign q_push.ent.clear     = in_bus.start_of_unit;

endmodule

// ===== sv/egsd_queue.sv =====
module egsd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  egsd_pkg::egsd_qpush_t q_push,
  output logic                  q_ready,
  output egsd_pkg::egsd_qpush_t q_head,
  input  logic                  q_pop
);
  import egsd_pkg::*;

  // two-entry queue between front and bit engine
  egsd_qent_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign q_ready      = (cnt_r != 2'd2);
  assign do_wr        = q_push.valid && q_ready;
  assign do_rd        = q_pop && (cnt_r != 2'd0);
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.ent   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= q_push.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= ~wr_ptr_r;
      if (do_rd) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/egsd_back.sv =====
`include "nal_exp_golomb_stream_decoder_macros.svh"

module egsd_back #(
  parameter int unsigned MAX_LEADING_ZEROS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  egsd_pkg::egsd_qpush_t q_head,
  output logic                  q_pop,
  egsd_out_if.source            out_bus
);
  import egsd_pkg::*;

  localparam logic [CNT_W-1:0] MAX_LZ = CNT_W'(MAX_LEADING_ZEROS);

  // configuration
  logic signed_mode_r;

  // current byte
  logic              cur_valid_r, cur_valid_nxt;
  logic [BYTE_W-1:0] sh_r, sh_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              flush_r, flush_nxt;

  // code state
  logic             rs_r, rs_nxt;
  logic [CNT_W-1:0] lzc_r, lzc_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  // held result, waiting to learn whether it is the last of its byte
  logic             pend_valid_r, pend_valid_nxt;
  logic [ACC_W-1:0] pend_k_r, pend_k_nxt;
  logic             pend_err_r, pend_err_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_err_r, out_err_nxt;
  logic               out_last_r, out_last_nxt;

  logic             advance, proc, last_bit, done, load, cur_bit;
  logic             res_v, res_err;
  logic [ACC_W-1:0] res_k, acc_shift;
  logic             push, push_err, push_last;
  logic [ACC_W-1:0] push_k;

  function automatic logic [VALUE_W-1:0] map_value(input logic [ACC_W-1:0] k,
                                                   input logic err,
                                                   input logic smode);
    logic [VALUE_W-1:0] kk;
    logic [VALUE_W-1:0] v;
    kk = {1'b0, k};
    if (err) begin
      v = '0;
    end else if (!smode) begin
      v = kk;
    end else if (k[0]) begin
      v = (kk + VALUE_W'(1)) >> 1;
    end else begin
      v = VALUE_W'(0) - (kk >> 1);
    end
    return v;
  endfunction

  assign advance   = !out_valid_r || out_bus.ready;
  assign proc      = advance && cur_valid_r && !flush_r;
  assign last_bit  = (idx_r == 3'd7);
  assign cur_bit   = sh_r[BYTE_W-1];
  assign acc_shift = {acc_r[ACC_W-2:0], cur_bit};

  // one bit of the code stream per cycle while the output advances and no flush is pending
  always_comb begin
    res_v    = 1'b0;
    res_err  = 1'b0;
    res_k    = '0;
    rs_nxt   = rs_r;
    lzc_nxt  = lzc_r;
    left_nxt = left_r;
    acc_nxt  = acc_r;
    if (proc) begin
      if (!rs_r) begin
        if (!cur_bit) begin
          if (lzc_r >= MAX_LZ) begin
            res_v   = 1'b1;
            res_err = 1'b1;
            lzc_nxt = '0;
          end else begin
            lzc_nxt = lzc_r + CNT_W'(1);
          end
        end else if (lzc_r == '0) begin
          res_v = 1'b1;
        end else begin
          rs_nxt   = 1'b1;
          left_nxt = lzc_r;
          acc_nxt  = ACC_W'(1);
        end
      end else begin
        acc_nxt  = acc_shift;
        left_nxt = left_r - CNT_W'(1);
        if (left_r == CNT_W'(1)) begin
          // leading one is kept in the accumulator, so k is one less
          res_v    = 1'b1;
          res_k    = acc_shift - ACC_W'(1);
          rs_nxt   = 1'b0;
          lzc_nxt  = '0;
          left_nxt = '0;
          acc_nxt  = '0;
        end
      end
    end
  end

  // result hand-off: hold one back until the next result or the end of its byte
  always_comb begin
    push           = 1'b0;
    push_k         = pend_k_r;
    push_err       = pend_err_r;
    push_last      = 1'b0;
    pend_valid_nxt = pend_valid_r;
    pend_k_nxt     = pend_k_r;
    pend_err_nxt   = pend_err_r;
    flush_nxt      = flush_r;
    if (advance && cur_valid_r && flush_r) begin
      push           = 1'b1;
      push_last      = 1'b1;
      pend_valid_nxt = 1'b0;
      flush_nxt      = 1'b0;
    end else if (proc) begin
      if (res_v && pend_valid_r) begin
        push         = 1'b1;
        pend_k_nxt   = res_k;
        pend_err_nxt = res_err;
        flush_nxt    = last_bit;
      end else if (res_v) begin
        if (last_bit) begin
          push      = 1'b1;
          push_k    = res_k;
          push_err  = res_err;
          push_last = 1'b1;
        end else begin
          pend_valid_nxt = 1'b1;
          pend_k_nxt     = res_k;
          pend_err_nxt   = res_err;
        end
      end else if (last_bit && pend_valid_r) begin
        push           = 1'b1;
        push_last      = 1'b1;
        pend_valid_nxt = 1'b0;
      end
    end
  end

  // byte sequencing and queue pop
  assign done  = advance && cur_valid_r &&
                 (flush_r || (last_bit && !(res_v && pend_valid_r)));
  assign load  = q_head.valid && (!cur_valid_r || done);
  assign q_pop = load;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    sh_nxt        = sh_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
      sh_nxt        = q_head.ent.data_byte;
      idx_nxt       = 3'd0;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (proc && !last_bit) begin
      sh_nxt  = {sh_r[BYTE_W-2:0], 1'b0};
      idx_nxt = idx_r + 3'd1;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = push;
      out_value_nxt = map_value(push_k, push_err, signed_mode_r);
      out_err_nxt   = push_err;
      out_last_nxt  = push_last;
    end
  end

  always_ff @(posedge clk) begin
    sh_r        <= sh_nxt;
    idx_r       <= idx_nxt;
    pend_k_r    <= pend_k_nxt;
    pend_err_r  <= pend_err_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
      cur_valid_r   <= 1'b0;
      flush_r       <= 1'b0;
      rs_r          <= 1'b0;
      lzc_r         <= '0;
      left_r        <= '0;
      acc_r         <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) signed_mode_r <= cfg_wr_data;
      cur_valid_r  <= cur_valid_nxt;
      flush_r      <= flush_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (load && q_head.ent.clear) begin
        // new unit: drop the unfinished code
        rs_r   <= 1'b0;
        lzc_r  <= '0;
        left_r <= '0;
        acc_r  <= '0;
      end else begin
        rs_r   <= rs_nxt;
        lzc_r  <= lzc_nxt;
        left_r <= left_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.code_value   = out_value_r;
  assign out_bus.code_error   = out_err_r;
  assign out_bus.last_of_byte = out_last_r;

  `EGSD_ASSERT_IMPL(a_flush_has_pend, clk, rst_n, flush_r, pend_valid_r && cur_valid_r)
  `EGSD_ASSERT_IMPL(a_suffix_left, clk, rst_n, rs_r, (left_r != '0) && (left_r <= lzc_r))
  `EGSD_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid_r && out_err_r, out_value_r == '0)

endmodule

// ===== sv/nal_exp_golomb_stream_decoder.sv =====
// Exp-Golomb stream decoder for coded video units.
// in_bus carries one raw byte per beat with start_of_unit, which clears the
// escape count and drops any unfinished code before that byte is used.
// After two zero bytes a 0x03 byte is removed; all other bits are decoded
// MSB first as a continuous run of Exp-Golomb codes. out_bus carries one
// beat per finished code: code_value (unsigned, or signed mapping when
// cfg_wr_data was written as 1), code_error for an over-long zero run,
// and last_of_byte on the final code of an input byte.
// Throughput: the bit engine consumes one bit per cycle while out_bus is
// not stalled, plus a flush step when the final bit of a byte finishes a
// code while an earlier code of the same byte is still held. A two-beat
// queue lets the front keep taking bytes while the engine works.
// An accepted byte goes through the queue into the engine's shift
// register, whose bits are then read in order. A finished code is held
// until the next code of that byte finishes or the byte ends; every code
// then leaves through the output register.
// Reset (synchronous, rst_n low) empties the queue and output register and
// clears all code state and signed mode. While out_bus.ready is low and a
// beat waits, the engine holds; the queue fills, then in_bus.ready drops.
module nal_exp_golomb_stream_decoder #(
  parameter int unsigned MAX_LEADING_ZEROS = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  egsd_in_if.sink     in_bus,
  egsd_out_if.source  out_bus
);
  import egsd_pkg::*;

  egsd_qpush_t q_push;
  egsd_qpush_t q_head;
  logic        q_ready;
  logic        q_pop;

  egsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .q_ready (q_ready),
    .q_push  (q_push)
  );

  egsd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_ready (q_ready),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  egsd_back #(
    .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_bus     (out_bus)
  );

endmodule

// ===== tb/sv/nal_exp_golomb_stream_decoder_tb.sv =====
`timescale 1ns / 100ps

module nal_exp_golomb_stream_decoder_tb;
  import egsd_pkg::*;

  localparam int MAX_LZ       = 31;
  localparam int DRAIN_CYCLES = 64;
  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_BYTES = 200;
  localparam int NUM_PHASES   = 4;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               err;
    logic               last;
  } code_result_t;

  // Golden decoder plus the queue of codes still owed by the block
  class egsd_scoreboard;
    bit                 signed_mode = 1'b0;
    logic [1:0]         zero_run = '0;
    bit                 in_suffix = 1'b0;
    logic [CNT_W-1:0]   lz_count = '0;
    logic [CNT_W-1:0]   bits_left = '0;
    logic [ACC_W-1:0]   acc = '0;
    code_result_t       owed_codes[$];
    int                 failures = 0;
    int                 checked = 0;
    int                 escapes = 0;
    int                 error_codes = 0;

    function void set_mode(bit m);
      signed_mode = m;
    endfunction

    function int pending();
      return owed_codes.size();
    endfunction

    function void drop_code();
      in_suffix = 1'b0;
      lz_count  = '0;
      bits_left = '0;
      acc       = '0;
    endfunction

    function logic [VALUE_W-1:0] map_code(logic [VALUE_W-1:0] k);
      if (!signed_mode) return k;
      if (k[0]) return (k + 33'd1) >> 1;
      return 33'd0 - (k >> 1);
    endfunction

    function void owe(logic [VALUE_W-1:0] value, logic err);
      code_result_t r;
      r.value = value;
      r.err   = err;
      r.last  = 1'b0;
      owed_codes.push_back(r);
    endfunction

    // Decode one accepted input beat
    function void note_byte(logic [BYTE_W-1:0] d, logic sou);
      int               start_len;
      int               b;
      logic [VALUE_W-1:0] k;
      code_result_t     r;
      if (sou) begin
        zero_run = '0;
        drop_code();
      end
      // emulation prevention byte
      if (zero_run >= 2 && d == BYTE_ESCAPE) begin
        zero_run = '0;
        escapes++;
        return;
      end
      if (d == BYTE_ZERO) begin
        if (zero_run < 2) zero_run++;
      end else begin
        zero_run = '0;
      end
      start_len = owed_codes.size();
      for (b = BYTE_W - 1; b >= 0; b--) begin
        if (!in_suffix) begin
          if (!d[b]) begin
            lz_count++;
            if (lz_count > MAX_LZ) begin
              owe('0, 1'b1);
              error_codes++;
              drop_code();
            end
          end else if (lz_count == 0) begin
            owe(map_code('0), 1'b0);
            drop_code();
          end else begin
            in_suffix = 1'b1;
            bits_left = lz_count;
            acc       = '0;
          end
        end else begin
          acc = {acc[ACC_W-2:0], d[b]};
          if (bits_left > 0) bits_left--;
          if (bits_left == 0) begin
            k = ((33'd1 << lz_count) - 33'd1) + {1'b0, acc};
            owe(map_code(k), 1'b0);
            drop_code();
          end
        end
      end
      // flag the final code of this byte
      if (owed_codes.size() > start_len) begin
        r = owed_codes.pop_back();
        r.last = 1'b1;
        owed_codes.push_back(r);
      end
    endfunction

    function void log_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %0s", msg);
    endfunction

    // Compare one output beat against the oldest owed code
    function void check_code(logic [VALUE_W-1:0] value, logic err, logic last);
      code_result_t want;
      checked++;
      if (owed_codes.size() == 0) begin
        log_failure($sformatf("unexpected beat value=%0d err=%0b last=%0b",
                              $signed(value), err, last));
        return;
      end
      want = owed_codes.pop_front();
      if (want.value !== value || want.err !== err || want.last !== last)
        log_failure($sformatf("beat %0d expected value=%0d err=%0b last=%0b, got value=%0d err=%0b last=%0b",
                              checked, $signed(want.value), want.err, want.last,
                              $signed(value), err, last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  egsd_in_if  in_bus();
  egsd_out_if out_bus();

  egsd_scoreboard sb = new;

  int  cycle_cnt = 0;
  int  bytes_sent = 0;
  int  stall_cnt = 0;
  bit  send_fast = 1'b0;
  bit  recv_fast = 1'b0;

  // Directed beats as {start_of_unit, data_byte}
  logic [BYTE_W:0] directed_seq [0:24] = '{
    // longest code: 31 zeros, a one, 31 ones, then a one-bit code
    9'h100, 9'h000, 9'h000, 9'h001, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
    // eight codes in one byte, escape after two zeros, plain 0x03 after it
    9'h1FF, 9'h080, 9'h000, 9'h000, 9'h003, 9'h003,
    // 32 zero bits: leading zero overflow
    9'h100, 9'h000, 9'h000, 9'h000,
    // long zero run then escape
    9'h100, 9'h000, 9'h000, 9'h003,
    // new unit drops an unfinished code
    9'h180, 9'h140, 9'h055
  };

  nal_exp_golomb_stream_decoder #(
    .MAX_LEADING_ZEROS(MAX_LZ)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_bus      (in_bus),
    .out_bus     (out_bus)
  );

  always #1 clk = ~clk;

  // Cycle watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("FAIL nal_exp_golomb_stream_decoder");
      $finish;
    end
  end

  // Result side: check each beat, then draw a stall before the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        sb.check_code(out_bus.code_value, out_bus.code_error, out_bus.last_of_byte);
        stall_cnt = recv_fast ? 0 : $urandom_range(15);
      end
      if (stall_cnt > 0) begin
        out_bus.ready <= 1'b0;
        stall_cnt--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // One input beat, after a random gap
  task automatic push_byte(input logic [BYTE_W-1:0] d, input logic sou);
    int gap;
    gap = send_fast ? 0 : $urandom_range(15);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.data_byte     <= d;
    in_bus.start_of_unit <= sou;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_byte(d, sou);
    bytes_sent++;
  endtask

  // Hold off input until every owed code is out and the engine is quiet
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_mode(m);
  endtask

  task automatic send_directed(input int first, input int count);
    int i;
    for (i = first; i < first + count; i++)
      push_byte(directed_seq[i][BYTE_W-1:0], directed_seq[i][BYTE_W]);
  endtask

  // Unit: random codes (some overflow runs), byte packed, escape bytes inserted, may be cut short
  task automatic send_unit(input int ncodes, input bit new_unit, input bit cut_short);
    bit               code_bits[$];
    int               c, i, j, r, lzn, nbytes, zc;
    logic [BYTE_W-1:0] byte_v;
    bit               first;
    for (c = 0; c < ncodes; c++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        // overflow run
        repeat (MAX_LZ + 1) code_bits.push_back(1'b0);
      end else begin
        lzn = (r < 70) ? $urandom_range(3) :
              (r < 95) ? $urandom_range(12, 4) : $urandom_range(MAX_LZ, 13);
        repeat (lzn) code_bits.push_back(1'b0);
        code_bits.push_back(1'b1);
        repeat (lzn) code_bits.push_back(1'($urandom_range(1)));
      end
    end
    while (code_bits.size() % BYTE_W != 0) code_bits.push_back(1'($urandom_range(1)));
    nbytes = code_bits.size() / BYTE_W;
    if (cut_short) nbytes = $urandom_range(nbytes, 1);
    first = new_unit;
    zc = 0;
    for (i = 0; i < nbytes; i++) begin
      for (j = 0; j < BYTE_W; j++) byte_v[BYTE_W-1-j] = code_bits[i*BYTE_W + j];
      if (zc >= 2 && byte_v <= BYTE_ESCAPE) begin
        push_byte(BYTE_ESCAPE, first);
        first = 1'b0;
        zc = 0;
      end
      push_byte(byte_v, first);
      first = 1'b0;
      zc = (byte_v == BYTE_ZERO) ? zc + 1 : 0;
    end
  endtask

  // Noise: zero-heavy raw bytes with stray unit starts
  task automatic send_noise(input int n);
    int               i, r;
    logic [BYTE_W-1:0] d;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35) d = BYTE_ZERO;
      else if (r < 50) d = BYTE_ESCAPE;
      else if (r < 60) d = BYTE_W'($urandom_range(2, 1));
      else d = BYTE_W'($urandom_range(255));
      push_byte(d, $urandom_range(9) == 0);
    end
  endtask

  // Main sequence
  initial begin
    int phase, section, phase_end, r;
    rst_n                = 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.data_byte     <= '0;
    in_bus.start_of_unit <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: whole list unsigned, longest code again signed
    write_mode(1'b0);
    send_directed(0, 25);
    write_mode(1'b1);
    send_directed(0, 8);

    // random phases, alternating the mapping
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_mode(phase % 2 == 1);
      phase_end = bytes_sent + RANDOM_BYTES / NUM_PHASES;
      section = 0;
      while (bytes_sent < phase_end) begin
        send_fast = ($urandom_range(3) == 0);
        recv_fast = ($urandom_range(3) == 0);
        if (section == 3) wait_idle();
        r = $urandom_range(99);
        if (r < 80)
          send_unit($urandom_range(12, 1), $urandom_range(4) != 0, $urandom_range(7) == 0);
        else
          send_noise($urandom_range(8, 1));
        section++;
      end
    end

    // drain
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes (%0d escapes removed), checked %0d codes, %0d overflow codes",
             bytes_sent, sb.escapes, sb.checked, sb.error_codes);
    $display("both mappings exercised; %0d mismatches", sb.failures);
    if (sb.failures == 0) begin
      $display("PASS nal_exp_golomb_stream_decoder");
    end else begin
      $display("FAIL nal_exp_golomb_stream_decoder");
    end
    $finish;
  end

endmodule

// ===== nal_exp_golomb_stream_decoder.f =====
+incdir+sv
sv/egsd_pkg.sv
sv/egsd_if.sv
sv/egsd_front.sv
sv/egsd_queue.sv
sv/egsd_back.sv
sv/nal_exp_golomb_stream_decoder.sv
tb/sv/nal_exp_golomb_stream_decoder_tb.sv
